// ----- sv/assert_macros.svh -----
// Shared assertion macros; clk and rst are the block's clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre at one edge implies post at the next, outside reset
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

// pre at one edge implies post at the next, reset included
`define ASSERT_NEXT_ANY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- sv/bsc_pkg.sv -----
`default_nettype none
package bsc_pkg;
  localparam int TEMP_FRAC_BITS_DEF  = 16;
  localparam int PRESS_FRAC_BITS_DEF = 8;
  localparam int PSCALE              = 181;
  localparam int LIMB_W              = 32;
  localparam int CAL_W               = 168;

  localparam logic [1:0] REG_CALIB_LO  = 2'd0;
  localparam logic [1:0] REG_CALIB_MID = 2'd1;
  localparam logic [1:0] REG_CALIB_HI  = 2'd2;

  localparam logic signed [23:0] TEMP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] TEMP_MIN = -24'sh800000;
  localparam logic [24:0]        PRESS_MAX = 25'h1FFFFFF;
endpackage
`default_nettype wire

// ----- sv/bsc_mul.sv -----
`default_nettype none
// Signed multiplier, four register stages: magnitudes, 32x32 partial
// products, partial product sum, sign.
module bsc_mul import bsc_pkg::*; #(
  parameter int WA = 60,
  parameter int WB = 34
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [WA-1:0]   a,
  input  wire logic signed [WB-1:0]   b,
  output logic signed [WA+WB-1:0]     p
);
  localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
  localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
  localparam int LA = NA * LIMB_W;
  localparam int LB = NB * LIMB_W;
  localparam int PW = WA + WB;

  logic [LA-1:0]         ma;
  logic [LB-1:0]         mb;
  logic                  neg1, neg2, neg3;
  logic [2*LIMB_W-1:0]   pp [NA][NB];
  logic [PW-1:0]         sum, sum_c;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_c = sum_c + (PW'(pp[i][j]) << (LIMB_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= LA'($unsigned(a[WA-1] ? -a : a));
      mb   <= LB'($unsigned(b[WB-1] ? -b : b));
      neg1 <= a[WA-1] ^ b[WB-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ma[i*LIMB_W +: LIMB_W] * mb[j*LIMB_W +: LIMB_W];
        end
      end
      neg2 <= neg1;
      sum  <= sum_c;
      neg3 <= neg2;
      p    <= neg3 ? $signed(-sum) : $signed(sum);
    end
  end
endmodule
`default_nettype wire

// ----- sv/baro_sensor_compensation.sv -----
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      tdata: raw_pressure, raw_temperature
// m_axis    out  tvalid/tready      tdata: temperature_q16, pressure_q8; tuser: saturated
// cfg       in   cfg_valid/ready    cfg_index, cfg_data (calibration words)
//
// One request accepted per cycle while m_axis is not stalled. The pipeline depth is set by the
// Horner chain in pressure: three dependent 4-stage multipliers.
// Synchronous reset clears valid bits and the calibration registers.
// A stall on m_axis freezes the whole pipeline; cfg_ready is always high.
`include "assert_macros.svh"
module baro_sensor_compensation import bsc_pkg::*; #(
  parameter int TEMP_FRAC_BITS  = TEMP_FRAC_BITS_DEF,
  parameter int PRESS_FRAC_BITS = PRESS_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // temperature_q16[23:0], pressure_q8[48:24]
  output logic             m_axis_tuser,   // saturated[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int NST   = 20;
  localparam int TSH   = 48 - TEMP_FRAC_BITS;
  localparam int PSH   = PSCALE - PRESS_FRAC_BITS;
  localparam int ACC_W = 220;

  logic [63:0] calib_lo, calib_mid;
  logic [39:0] calib_hi;
  logic [CAL_W-1:0] cal;

  logic [NST:1] v;
  logic         adv;

  // coefficients
  logic [15:0] c_t1;
  logic signed [16:0] c_t2, c_p1m, c_p2m, c_p5, c_p6;
  logic signed [7:0]  c_t3, c_p3, c_p4, c_p7, c_p8, c_p10, c_p11;
  logic signed [15:0] c_p9;

  assign cal   = {calib_hi, calib_mid, calib_lo};
  assign c_t1  = cal[15:0];
  assign c_t2  = $signed({1'b0, cal[31:16]});
  assign c_t3  = $signed(cal[39:32]);
  assign c_p1m = $signed({cal[55], cal[55:40]}) - 17'sd16384;
  assign c_p2m = $signed({cal[71], cal[71:56]}) - 17'sd16384;
  assign c_p3  = $signed(cal[79:72]);
  assign c_p4  = $signed(cal[87:80]);
  assign c_p5  = $signed({1'b0, cal[103:88]});
  assign c_p6  = $signed({1'b0, cal[119:104]});
  assign c_p7  = $signed(cal[127:120]);
  assign c_p8  = $signed(cal[135:128]);
  assign c_p9  = $signed(cal[151:136]);
  assign c_p10 = $signed(cal[159:152]);
  assign c_p11 = $signed(cal[167:160]);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_lo  <= '0;
      calib_mid <= '0;
      calib_hi  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CALIB_LO:  calib_lo  <= cfg_data;
        REG_CALIB_MID: calib_mid <= cfg_data;
        REG_CALIB_HI:  calib_hi  <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // advance everything unless the output request is held
  assign adv           = !v[NST] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-1:1], s_axis_tvalid};
    end
  end

  // stage registers
  logic [23:0]         up1, up2;
  logic signed [24:0]  d1;
  logic signed [40:0]  dt2_2, dt2_3;
  logic signed [49:0]  dd_2;
  logic [47:0]         u2_2;
  logic signed [32:0]  p4u_2, p3u_2;
  logic signed [41:0]  p1u_2, p2u_2;
  logic signed [57:0]  ddt3_3;
  logic [71:0]         u3_3;
  logic signed [65:0]  p9u2_3;
  logic signed [56:0]  p10u2_3;
  logic signed [33:0]  a3_3, a3_4;
  logic signed [147:0] a1p_3;
  logic signed [204:0] a0p_3, a0q_4;
  logic signed [80:0]  p11u3_4;

  logic signed [24:0]  up1_s;
  logic signed [48:0]  u2_s;
  logic signed [72:0]  u3_s;
  logic signed [86:0]  a2_c;
  logic signed [147:0] a1_c;
  logic signed [204:0] a0_c;
  logic signed [59:0]  t48_c;
  logic signed [60:0]  tr_c, tqf_c;
  logic signed [23:0]  tq_c;
  logic                tsat_c;

  localparam int T48_N = 11;
  localparam int A2_N  = 6;
  localparam int A1_N  = 10;
  localparam int A0_N  = 14;
  localparam int TQ_N  = 16;

  logic signed [59:0]  t48_s [T48_N];
  logic signed [86:0]  a2_s  [A2_N];
  logic signed [147:0] a1_s  [A1_N];
  logic signed [204:0] a0_s  [A0_N];
  logic signed [23:0]  tq_s  [TQ_N];
  logic                tsat_s [TQ_N];

  logic signed [93:0]      m1;
  logic signed [154:0]     m2;
  logic signed [216:0]     m3;
  logic signed [94:0]      b2_9;
  logic signed [156:0]     b1_14;
  logic signed [ACC_W-1:0] acc_19;
  logic [24:0]             press_q;
  logic                    psat;

  assign up1_s = $signed({1'b0, up1});
  assign u2_s  = $signed({1'b0, u2_2});
  assign u3_s  = $signed({1'b0, u3_3});

  always_comb begin
    a2_c  = (87'(c_p7) <<< 77) + (87'(p3u_2) <<< 53);
    a1_c  = a1p_3 + (148'(p10u2_3) <<< 85);
    a0_c  = a0q_4 + (205'(p11u3_4) <<< 116);
    t48_c = (60'(dt2_3) <<< 18) + 60'(ddt3_3);
    tr_c  = 61'(t48_s[0]) + (61'sd1 <<< (TSH - 1));
    tqf_c = tr_c >>> TSH;
    tsat_c = 1'b0;
    if (tqf_c > 61'(TEMP_MAX)) begin
      tq_c   = TEMP_MAX;
      tsat_c = 1'b1;
    end else if (tqf_c < 61'(TEMP_MIN)) begin
      tq_c   = TEMP_MIN;
      tsat_c = 1'b1;
    end else begin
      tq_c = tqf_c[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      up1 <= s_axis_tdata[23:0];
      d1  <= $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, c_t1, 8'h00});
      // stage 2
      dt2_2 <= d1 * c_t2;
      dd_2  <= d1 * d1;
      u2_2  <= up1 * up1;
      up2   <= up1;
      p4u_2 <= c_p4 * up1_s;
      p3u_2 <= c_p3 * up1_s;
      p1u_2 <= c_p1m * up1_s;
      p2u_2 <= c_p2m * up1_s;
      // stage 3
      ddt3_3  <= dd_2 * c_t3;
      dt2_3   <= dt2_2;
      u3_3    <= u2_2 * up2;
      p9u2_3  <= c_p9 * u2_s;
      p10u2_3 <= c_p10 * u2_s;
      a3_3    <= (34'(c_p8) <<< 22) + 34'(p4u_2);
      a1p_3   <= (148'(c_p6) <<< 127) + (148'(p2u_2) <<< 104);
      a0p_3   <= (205'(c_p5) <<< 184) + (205'(p1u_2) <<< 161);
      // stage 4
      a3_4    <= a3_3;
      a0q_4   <= a0p_3 + (205'(p9u2_3) <<< 133);
      p11u3_4 <= c_p11 * u3_s;
      // delay lines
      t48_s[0]  <= t48_c;
      a2_s[0]   <= a2_c;
      a1_s[0]   <= a1_c;
      a0_s[0]   <= a0_c;
      tq_s[0]   <= tq_c;
      tsat_s[0] <= tsat_c;
      for (int k = 1; k < T48_N; k++) t48_s[k] <= t48_s[k-1];
      for (int k = 1; k < A2_N; k++)  a2_s[k]  <= a2_s[k-1];
      for (int k = 1; k < A1_N; k++)  a1_s[k]  <= a1_s[k-1];
      for (int k = 1; k < A0_N; k++)  a0_s[k]  <= a0_s[k-1];
      for (int k = 1; k < TQ_N; k++) begin
        tq_s[k]   <= tq_s[k-1];
        tsat_s[k] <= tsat_s[k-1];
      end
      // Horner steps
      b2_9   <= 95'(m1) + 95'(a2_s[A2_N-1]);
      b1_14  <= 157'(m2) + 157'(a1_s[A1_N-1]);
      acc_19 <= ACC_W'(m3) + ACC_W'(a0_s[A0_N-1]) + (ACC_W'(1) <<< (PSH - 1));
      // stage 20: clip pressure
      if (acc_19[ACC_W-1]) begin
        press_q <= '0;
        psat    <= 1'b1;
      end else if (|acc_19[ACC_W-2:PSH+25]) begin
        press_q <= PRESS_MAX;
        psat    <= 1'b1;
      end else begin
        press_q <= acc_19[PSH+24:PSH];
        psat    <= 1'b0;
      end
    end
  end

  bsc_mul #(.WA(60), .WB(34)) u_mul1 (
    .clk(clk), .en(adv), .a(t48_s[0]), .b(a3_4), .p(m1)
  );
  bsc_mul #(.WA(60), .WB(95)) u_mul2 (
    .clk(clk), .en(adv), .a(t48_s[5]), .b(b2_9), .p(m2)
  );
  bsc_mul #(.WA(60), .WB(157)) u_mul3 (
    .clk(clk), .en(adv), .a(t48_s[10]), .b(b1_14), .p(m3)
  );

  assign m_axis_tvalid = v[NST];
  assign m_axis_tdata  = {7'd0, press_q, tq_s[TQ_N-1]};
  assign m_axis_tuser  = tsat_s[TQ_N-1] | psat;

  `ASSERT_NEXT_ANY(a_rst_empty, rst, !m_axis_tvalid)
  `ASSERT_NEXT(a_hold_valid, !adv, v == $past(v))
  `ASSERT_NEXT(a_neg_press, adv && v[NST-1] && acc_19[ACC_W-1],
               m_axis_tuser && m_axis_tdata[48:24] == 25'd0)
endmodule
`default_nettype wire

// ----- dv/baro_sensor_compensation_checker.sv -----
module baro_sensor_compensation_checker import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [55:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output int               errors,
  output int               pending
);
  typedef struct packed {
    logic [23:0] temp_q;
    logic [24:0] press_q;
    logic        sat;
  } comp_result_t;

  localparam int TSH = 48 - TEMP_FRAC_BITS_DEF;
  localparam int PSH = PSCALE - PRESS_FRAC_BITS_DEF;

  logic [63:0]  cal_lo, cal_mid;
  logic [39:0]  cal_hi;
  comp_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic comp_result_t compensate(input logic [23:0] up, input logic [23:0] ut);
    logic [167:0]         cal;
    logic signed [63:0]   t1c, t2c, t3c, d, t48, tq;
    logic signed [255:0]  p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic signed [255:0]  one, tw1, tw2, tw3, uw1, uw2, uw3, acc, shifted;
    comp_result_t         r;
    cal = {cal_hi, cal_mid, cal_lo};
    r.sat = 1'b0;
    t1c = {48'd0, cal[15:8], cal[7:0]};
    t2c = {48'd0, cal[31:24], cal[23:16]};
    t3c = {{56{cal[39]}}, cal[39:32]};
    d   = $signed({40'd0, ut}) - t1c * 256;
    t48 = d * t2c * 262144 + d * d * t3c;
    tq  = (t48 + (64'sd1 <<< (TSH - 1))) >>> TSH;
    if (tq > 64'sd8388607) begin
      tq = 64'sd8388607;
      r.sat = 1'b1;
    end
    if (tq < -64'sd8388608) begin
      tq = -64'sd8388608;
      r.sat = 1'b1;
    end
    r.temp_q = tq[23:0];

    p1  = $signed({{240{cal[55]}}, cal[55:40]}) - 256'sd16384;
    p2  = $signed({{240{cal[71]}}, cal[71:56]}) - 256'sd16384;
    p3  = $signed({{248{cal[79]}}, cal[79:72]});
    p4  = $signed({{248{cal[87]}}, cal[87:80]});
    p5  = $signed({240'd0, cal[103:88]});
    p6  = $signed({240'd0, cal[119:104]});
    p7  = $signed({{248{cal[127]}}, cal[127:120]});
    p8  = $signed({{248{cal[135]}}, cal[135:128]});
    p9  = $signed({{240{cal[151]}}, cal[151:136]});
    p10 = $signed({{248{cal[159]}}, cal[159:152]});
    p11 = $signed({{248{cal[167]}}, cal[167:160]});
    one = 256'sd1;
    tw1 = $signed({{192{t48[63]}}, t48});
    tw2 = tw1 * tw1;
    tw3 = tw2 * tw1;
    uw1 = $signed({232'd0, up});
    uw2 = uw1 * uw1;
    uw3 = uw2 * uw1;
    // exact sum at PSCALE fraction bits, wrapping mod 2^256
    acc = (p5 * one) <<< 184;
    acc = acc + ((p6 * tw1) <<< 127);
    acc = acc + ((p7 * tw2) <<< 77);
    acc = acc + ((p8 * tw3) <<< 22);
    acc = acc + ((p1 * uw1) <<< 161);
    acc = acc + ((p2 * (uw1 * tw1)) <<< 104);
    acc = acc + ((p3 * (uw1 * tw2)) <<< 53);
    acc = acc + (p4 * (uw1 * tw3));
    acc = acc + ((p9 * uw2) <<< 133);
    acc = acc + ((p10 * (uw2 * tw1)) <<< 85);
    acc = acc + ((p11 * uw3) <<< 116);
    acc = acc + (one <<< (PSH - 1));
    if (acc[255]) begin
      r.press_q = '0;
      r.sat = 1'b1;
    end else begin
      shifted = acc >>> PSH;
      if (shifted > $signed({231'd0, PRESS_MAX})) begin
        r.press_q = PRESS_MAX;
        r.sat = 1'b1;
      end else begin
        r.press_q = shifted[24:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    comp_result_t want;
    if (rst) begin
      cal_lo  <= '0;
      cal_mid <= '0;
      cal_hi  <= '0;
      errors  <= 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CALIB_LO: begin
            cal_lo <= cfg_data;
          end
          REG_CALIB_MID: begin
            cal_mid <= cfg_data;
          end
          REG_CALIB_HI: begin
            cal_hi <= cfg_data[39:0];
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(compensate(s_axis_tdata[23:0], s_axis_tdata[47:24]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected result %h sat %b", m_axis_tdata, m_axis_tuser);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[23:0] !== want.temp_q || m_axis_tdata[48:24] !== want.press_q ||
              m_axis_tuser !== want.sat) begin
            if (errors < 10)
              $display("mismatch: temp exp %h got %h, press exp %h got %h, sat exp %b got %b",
                       want.temp_q, m_axis_tdata[23:0], want.press_q, m_axis_tdata[48:24],
                       want.sat, m_axis_tuser);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/baro_sensor_compensation_tb.sv -----
module baro_sensor_compensation_tb import bsc_pkg::*;;
  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] REG_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          errors, pending;
  logic        s_taken = 1'b0, cfg_taken = 1'b0;
  logic        no_idle = 1'b0;
  int          stall_cycles = 0;
  int          sink_burst = 0;
  logic [15:0] temp_base;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  baro_sensor_compensation dut (.*);

  baro_sensor_compensation_checker checker_i (.*);

  always @(posedge clk) begin
    s_taken   <= s_axis_tvalid && s_axis_tready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result sink with random back-pressure bursts
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready = 1'b0;
    end else if (no_idle) begin
      m_axis_tready = 1'b1;
    end else if (sink_burst > 0) begin
      sink_burst--;
      m_axis_tready = 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      sink_burst = $urandom_range(0, 17);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  task automatic load_calib(input logic [167:0] cal);
    drain();
    write_reg(REG_CALIB_LO, cal[63:0]);
    write_reg(REG_CALIB_MID, cal[127:64]);
    write_reg(REG_CALIB_HI, {24'd0, cal[167:128]});
    temp_base = cal[15:0];
  endtask

  task automatic send_sample(input logic [23:0] up, input logic [23:0] ut);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {ut, up};
    do @(negedge clk); while (!s_taken);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [167:0] plausible_calib();
    logic [167:0] c;
    c = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    c[15:0]   = 16'd27000 + 16'($urandom_range(0, 2000));
    c[31:16]  = 16'd19000 + 16'($urandom_range(0, 2000));
    c[39:32]  = 8'($urandom_range(0, 15)) - 8'd8;
    c[55:40]  = 16'($urandom_range(0, 4000)) - 16'd2000;
    c[71:56]  = 16'($urandom_range(0, 4000)) - 16'd2000;
    c[103:88] = 16'd20000 + 16'($urandom_range(0, 8000));
    c[119:104] = 16'd28000 + 16'($urandom_range(0, 8000));
    return c;
  endfunction

  // raw temperature mostly near the calibration offset
  function automatic logic [23:0] near_temp();
    int signed v;
    v = int'(temp_base) * 256 + int'($urandom_range(0, 2000000)) - 1000000;
    if (v < 0) v = 0;
    if (v > 32'sd16777215) v = 32'sd16777215;
    return v[23:0];
  endfunction

  initial begin
    logic [167:0] cal;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed: all-zero, all-one and plausible calibrations with field extremes
    load_calib('0);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
    load_calib({168{1'b1}});
    write_reg(REG_NONE, 64'h0123_4567_89AB_CDEF);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h555555, 24'hAAAAAA);
    send_sample(24'hAAAAAA, 24'h555555);
    cal = plausible_calib();
    load_calib(cal);
    send_sample(24'd6000000, {cal[15:0], 8'd0});
    send_sample(24'd6000000, near_temp());
    send_sample(24'h000000, near_temp());
    send_sample(24'hFFFFFF, near_temp());
    send_sample(24'd8000000, 24'h000000);
    send_sample(24'd8000000, 24'hFFFFFF);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) no_idle = 1'b1;
      if (phase == 2) begin
        load_calib(168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
      end else if (phase == 4) begin
        load_calib({{64{1'b1}}, {64{1'b1}}, 40'd0});
      end else begin
        load_calib(plausible_calib());
      end
      for (int n = 0; n < 100; n++) begin
        if (phase == 1 && n == 50) while (pending != 0) @(negedge clk);
        if ($urandom_range(0, 9) < 7)
          send_sample(24'($urandom), near_temp());
        else
          send_sample(24'($urandom), 24'($urandom));
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/bsc_pkg.sv
sv/bsc_mul.sv
sv/baro_sensor_compensation.sv
dv/baro_sensor_compensation_checker.sv
dv/baro_sensor_compensation_tb.sv
